// ===== src/trsmb_pkg.sv =====
// Shared constants and functions for the model-matrix builder.
// Used by the sine/cosine pipeline and the top level; no dependencies.
package trsmb_pkg;

    localparam int unsigned CordicSteps = 15;
    localparam logic signed [18:0] CordicGain = 19'sd39797;
    localparam logic signed [31:0] QOne = 32'sd65536;

    // Arctangent of 2^-i in binary-angle units.
    function automatic logic [13:0] atan_lookup(input logic [3:0] idx);
        logic [13:0] v;
        begin
            case (idx)
                4'd0:  v = 14'd8192;
                4'd1:  v = 14'd4836;
                4'd2:  v = 14'd2555;
                4'd3:  v = 14'd1297;
                4'd4:  v = 14'd651;
                4'd5:  v = 14'd326;
                4'd6:  v = 14'd163;
                4'd7:  v = 14'd81;
                4'd8:  v = 14'd41;
                4'd9:  v = 14'd20;
                4'd10: v = 14'd10;
                4'd11: v = 14'd5;
                4'd12: v = 14'd3;
                4'd13: v = 14'd1;
                4'd14: v = 14'd1;
                default: v = 14'd0;
            endcase
            return v;
        end
    endfunction

    // Rounded Q16.16 product with saturation to 32 bits.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [63:0] t;
        begin
            t = (p + 64'sd32768) >>> 16;
            if (t > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (t < -64'sd2147483648)
                return 32'sh80000000;
            else
                return t[31:0];
        end
    endfunction

endpackage

// ===== src/trsmb_sincos.sv =====
// Pipelined 15-step CORDIC giving Q16.16 cosine and sine of a binary angle.
// Depends on trsmb_pkg; one stage per rotation step plus entry and exit stages.
module trsmb_sincos
    import trsmb_pkg::*;
(
    input  logic                clk,
    input  logic [15:0]         angle,
    output logic signed [31:0]  cos_val,
    output logic signed [31:0]  sin_val
);

    localparam int unsigned NS = CordicSteps + 1;

    logic signed [18:0] x_reg [NS];
    logic signed [18:0] y_reg [NS];
    logic signed [16:0] z_reg [NS];
    logic [1:0]         q_reg [NS];
    logic signed [31:0] cos_reg, sin_reg;
    logic [15:0]        quad_sum;
    logic [15:0]        resid;

    assign quad_sum = angle + 16'd8192;
    assign resid    = angle - {quad_sum[15:14], 14'd0};

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CordicGain;
        y_reg[0] <= '0;
        z_reg[0] <= {resid[15], resid};
        q_reg[0] <= quad_sum[15:14];
    end

    for (genvar i = 0; i < CordicSteps; i++) begin : g_step
        logic signed [18:0] xs, ys;
        logic signed [16:0] at;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = signed'({3'd0, atan_lookup(4'(i))});
        always_ff @(posedge clk)
        begin
            q_reg[i+1] <= q_reg[i];
            if (!z_reg[i][16])
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + at;
            end
        end
    end

    logic signed [31:0] xc, yc;
    always_comb
    begin
        xc = 32'(x_reg[NS-1]);
        yc = 32'(y_reg[NS-1]);
        if (xc > QOne) xc = QOne;
        if (xc < -QOne) xc = -QOne;
        if (yc > QOne) yc = QOne;
        if (yc < -QOne) yc = -QOne;
    end

    always_ff @(posedge clk)
    begin
        case (q_reg[NS-1])
            2'd0:    begin cos_reg <= xc;  sin_reg <= yc;  end
            2'd1:    begin cos_reg <= -yc; sin_reg <= xc;  end
            2'd2:    begin cos_reg <= -xc; sin_reg <= -yc; end
            default: begin cos_reg <= yc;  sin_reg <= -xc; end
        endcase
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== src/trs_model_matrix_build_top.sv =====
// Top level of the translate-rotate-scale model-matrix builder.
// Depends on trsmb_pkg and trsmb_sincos.
//
// One item enters on a start beat when busy is low and comes out as four column beats on
// consecutive cycles, column 0 first, each marked by strobe, with last_column on column
// three. The receiver cannot stall, so the pipeline never holds. Busy stays high after
// each accepted start while a gap counter runs down, so items are spaced to match the
// four-beat output. The path from start to the column 0 beat runs through the CORDIC,
// three multiply stages (rotation products, triple products and sums, scale), and the
// column sequencer.
module trs_model_matrix_build_top
    import trsmb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        angle_x,
    input  logic [15:0]        angle_y,
    input  logic [15:0]        angle_z,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    output logic               strobe,
    output logic [1:0]         column_index,
    output logic signed [31:0] row_zero,
    output logic signed [31:0] row_one,
    output logic signed [31:0] row_two,
    output logic signed [31:0] row_three,
    output logic               last_column
);

    localparam int unsigned CDly = CordicSteps + 2;

    logic       accept;
    logic [1:0] gap_reg;
    assign accept = start && !busy;
    assign busy   = (gap_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= '0;
        else if (accept)
            gap_reg <= 2'd3;
        else if (gap_reg != 2'd0)
            gap_reg <= gap_reg - 2'd1;
    end

    logic signed [31:0] cx, sx, cy, sy, cz, sz;
    trsmb_sincos u_x (.clk(clk), .angle(angle_x), .cos_val(cx), .sin_val(sx));
    trsmb_sincos u_y (.clk(clk), .angle(angle_y), .cos_val(cy), .sin_val(sy));
    trsmb_sincos u_z (.clk(clk), .angle(angle_z), .cos_val(cz), .sin_val(sz));

    // Pass-along of position and scale beside the CORDIC pipeline.
    logic [CDly-1:0]    vld_reg;
    logic signed [31:0] px_reg [CDly], py_reg [CDly], pz_reg [CDly];
    logic signed [31:0] kx_reg [CDly], ky_reg [CDly], kz_reg [CDly];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[CDly-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        px_reg[0] <= pos_x;   py_reg[0] <= pos_y;   pz_reg[0] <= pos_z;
        kx_reg[0] <= scale_x; ky_reg[0] <= scale_y; kz_reg[0] <= scale_z;
        for (int i = 1; i < CDly; i++)
        begin
            px_reg[i] <= px_reg[i-1]; py_reg[i] <= py_reg[i-1]; pz_reg[i] <= pz_reg[i-1];
            kx_reg[i] <= kx_reg[i-1]; ky_reg[i] <= ky_reg[i-1]; kz_reg[i] <= kz_reg[i-1];
        end
    end

    // Stage A: plain rotation products and the two sy products.
    logic               a_vld_reg;
    logic signed [31:0] a_czcy_reg, a_szcy_reg, a_nsy_reg, a_szcx_reg, a_czcx_reg;
    logic signed [31:0] a_cysx_reg, a_cycx_reg, a_szsx_reg, a_czsx_reg;
    logic signed [31:0] a_sysx_reg, a_sycx_reg, a_cz_reg, a_sz_reg;
    logic signed [31:0] a_px_reg, a_py_reg, a_pz_reg, a_kx_reg, a_ky_reg, a_kz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) a_vld_reg <= 1'b0;
        else        a_vld_reg <= vld_reg[CDly-1];
    end

    always_ff @(posedge clk)
    begin
        a_czcy_reg <= qround(64'(cz) * 64'(cy));
        a_szcy_reg <= qround(64'(sz) * 64'(cy));
        a_nsy_reg  <= -sy;
        a_szcx_reg <= qround(64'(sz) * 64'(cx));
        a_czcx_reg <= qround(64'(cz) * 64'(cx));
        a_cysx_reg <= qround(64'(cy) * 64'(sx));
        a_cycx_reg <= qround(64'(cy) * 64'(cx));
        a_szsx_reg <= qround(64'(sz) * 64'(sx));
        a_czsx_reg <= qround(64'(cz) * 64'(sx));
        a_sysx_reg <= qround(64'(sy) * 64'(sx));
        a_sycx_reg <= qround(64'(sy) * 64'(cx));
        a_cz_reg <= cz; a_sz_reg <= sz;
        a_px_reg <= px_reg[CDly-1]; a_py_reg <= py_reg[CDly-1]; a_pz_reg <= pz_reg[CDly-1];
        a_kx_reg <= kx_reg[CDly-1]; a_ky_reg <= ky_reg[CDly-1]; a_kz_reg <= kz_reg[CDly-1];
    end

    // Stage B: triple products combined into the rotation matrix.
    logic               b_vld_reg;
    logic signed [31:0] b_m_reg [9];
    logic signed [31:0] b_px_reg, b_py_reg, b_pz_reg, b_kx_reg, b_ky_reg, b_kz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) b_vld_reg <= 1'b0;
        else        b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_m_reg[0] <= a_czcy_reg;
        b_m_reg[1] <= a_szcy_reg;
        b_m_reg[2] <= a_nsy_reg;
        b_m_reg[3] <= qround(64'(a_cz_reg) * 64'(a_sysx_reg)) - a_szcx_reg;
        b_m_reg[4] <= qround(64'(a_sz_reg) * 64'(a_sysx_reg)) + a_czcx_reg;
        b_m_reg[5] <= a_cysx_reg;
        b_m_reg[6] <= qround(64'(a_cz_reg) * 64'(a_sycx_reg)) + a_szsx_reg;
        b_m_reg[7] <= qround(64'(a_sz_reg) * 64'(a_sycx_reg)) - a_czsx_reg;
        b_m_reg[8] <= a_cycx_reg;
        b_px_reg <= a_px_reg; b_py_reg <= a_py_reg; b_pz_reg <= a_pz_reg;
        b_kx_reg <= a_kx_reg; b_ky_reg <= a_ky_reg; b_kz_reg <= a_kz_reg;
    end

    // Stage C: column scaling; the result lands in a four-column holding bank.
    logic               c_vld_reg;
    logic signed [31:0] c_m_reg [9];
    logic signed [31:0] c_px_reg, c_py_reg, c_pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) c_vld_reg <= 1'b0;
        else        c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_vld_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                c_m_reg[r]   <= qround(64'(b_m_reg[r])   * 64'(b_kx_reg));
                c_m_reg[3+r] <= qround(64'(b_m_reg[3+r]) * 64'(b_ky_reg));
                c_m_reg[6+r] <= qround(64'(b_m_reg[6+r]) * 64'(b_kz_reg));
            end
            c_px_reg <= b_px_reg; c_py_reg <= b_py_reg; c_pz_reg <= b_pz_reg;
        end
    end

    // Output sequencer: a column counter walks the held matrix one beat per cycle.
    // With busy-limited spacing, the next matrix lands in stage C just as column
    // three goes out. The rotation entries are done by then, but the position is
    // copied into its own registers when the walk starts so column three stays intact.
    logic       out_act_reg;
    logic [1:0] col_reg;
    logic signed [31:0] o_px_reg, o_py_reg, o_pz_reg;

    always_ff @(posedge clk)
    begin
        if (c_vld_reg)
        begin
            o_px_reg <= c_px_reg; o_py_reg <= c_py_reg; o_pz_reg <= c_pz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_act_reg <= 1'b0;
            col_reg     <= '0;
        end
        else if (c_vld_reg)
        begin
            out_act_reg <= 1'b1;
            col_reg     <= '0;
        end
        else if (out_act_reg)
        begin
            col_reg <= col_reg + 2'd1;
            if (col_reg == 2'd3)
                out_act_reg <= 1'b0;
        end
    end

    always_comb
    begin
        case (col_reg)
            2'd0:
            begin
                row_zero = c_m_reg[0]; row_one = c_m_reg[1]; row_two = c_m_reg[2];
                row_three = '0;
            end
            2'd1:
            begin
                row_zero = c_m_reg[3]; row_one = c_m_reg[4]; row_two = c_m_reg[5];
                row_three = '0;
            end
            2'd2:
            begin
                row_zero = c_m_reg[6]; row_one = c_m_reg[7]; row_two = c_m_reg[8];
                row_three = '0;
            end
            default:
            begin
                row_zero = o_px_reg; row_one = o_py_reg; row_two = o_pz_reg;
                row_three = QOne;
            end
        endcase
    end

    assign strobe       = out_act_reg;
    assign column_index = col_reg;
    assign last_column  = out_act_reg && (col_reg == 2'd3);

    // A new matrix must never arrive while a column walk is under way, except on its last beat.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |-> (!out_act_reg || col_reg == 2'd3))
        else $error("matrix arrived during column walk");

    // Every matrix that lands in stage C starts the output walk at column 0.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg |=> (out_act_reg && col_reg == 2'd0))
        else $error("column walk did not start");

    // The last column beat closes the walk.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        last_column |=> (!strobe || column_index == 2'd0))
        else $error("walk ran past column three");

endmodule

// ===== bench/trsmb_checker.sv =====
// Checker for the model-matrix builder: watches start/busy and the column beats,
// predicts the four columns of each accepted item and compares them field by field.
// Depends on nothing but the ports of trs_model_matrix_build_top.
module trsmb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        angle_x,
    input  logic [15:0]        angle_y,
    input  logic [15:0]        angle_z,
    input  logic signed [31:0] scale_x,
    input  logic signed [31:0] scale_y,
    input  logic signed [31:0] scale_z,
    input  logic               strobe,
    input  logic [1:0]         column_index,
    input  logic signed [31:0] row_zero,
    input  logic signed [31:0] row_one,
    input  logic signed [31:0] row_two,
    input  logic signed [31:0] row_three,
    input  logic               last_column,
    output int                 fail_count,
    output int                 columns_pending
);

    typedef struct packed {
        logic [1:0]         col;
        logic signed [31:0] r0;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] r3;
        logic               last;
    } column_t;

    column_t expected_columns[$];

    localparam longint UnitQ = 65536;

    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return sat_q((a * b + 32768) >>> 16);
    endfunction

    function automatic longint atan_step(input int i);
        case (i)
            0: return 8192;   1: return 4836;  2: return 2555;  3: return 1297;
            4: return 651;    5: return 326;   6: return 163;   7: return 81;
            8: return 41;     9: return 20;    10: return 10;   11: return 5;
            12: return 3;     default: return 1;
        endcase
    endfunction

    task automatic sine_cosine(input logic [15:0] ang, output longint c, output longint s);
        logic [1:0]  quad;
        logic [15:0] resid;
        longint      x, y, z, xs, ys;
        quad  = 2'((ang + 17'd8192) >> 14);
        resid = ang - {quad, 14'd0};
        z = longint'($signed(resid));
        x = 39797;
        y = 0;
        for (int i = 0; i < 15; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step(i);
            end
            else
            begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        if (x > UnitQ) x = UnitQ;
        if (x < -UnitQ) x = -UnitQ;
        if (y > UnitQ) y = UnitQ;
        if (y < -UnitQ) y = -UnitQ;
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Appends one expected column beat at the tail of the queue.
    task automatic queue_column(input column_t beat);
        expected_columns = {expected_columns, beat};
    endtask

    task automatic predict_matrix();
        longint  cx, sx, cy, sy, cz, sz, sysx, sycx;
        longint  m[3][3];
        longint  sc[3];
        column_t e;
        sine_cosine(angle_x, cx, sx);
        sine_cosine(angle_y, cy, sy);
        sine_cosine(angle_z, cz, sz);
        sc[0] = scale_x; sc[1] = scale_y; sc[2] = scale_z;
        sysx = fx_mul(sy, sx);
        sycx = fx_mul(sy, cx);
        m[0][0] = fx_mul(cz, cy);
        m[0][1] = fx_mul(sz, cy);
        m[0][2] = -sy;
        m[1][0] = fx_mul(cz, sysx) - fx_mul(sz, cx);
        m[1][1] = fx_mul(sz, sysx) + fx_mul(cz, cx);
        m[1][2] = fx_mul(cy, sx);
        m[2][0] = fx_mul(cz, sycx) + fx_mul(sz, sx);
        m[2][1] = fx_mul(sz, sycx) - fx_mul(cz, sx);
        m[2][2] = fx_mul(cy, cx);
        for (int c = 0; c < 3; c++)
        begin
            e.col  = 2'(c);
            e.r0   = 32'(fx_mul(m[c][0], sc[c]));
            e.r1   = 32'(fx_mul(m[c][1], sc[c]));
            e.r2   = 32'(fx_mul(m[c][2], sc[c]));
            e.r3   = '0;
            e.last = 1'b0;
            queue_column(e);
        end
        e.col = 2'd3; e.r0 = pos_x; e.r1 = pos_y; e.r2 = pos_z;
        e.r3 = 32'(UnitQ); e.last = 1'b1;
        queue_column(e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        column_t e;
        if (!rst_n)
        begin
            fail_count = 0;
        end
        else
        begin
            if (start && !busy)
                predict_matrix();
            if (strobe)
            begin
                if (expected_columns.size() == 0)
                    report_mismatch("unexpected column beat, index", column_index, -1);
                else
                begin
                    e = expected_columns.pop_front();
                    if (column_index !== e.col)
                        report_mismatch("column_index", column_index, e.col);
                    if (row_zero !== e.r0)
                        report_mismatch("row_zero", row_zero, e.r0);
                    if (row_one !== e.r1)
                        report_mismatch("row_one", row_one, e.r1);
                    if (row_two !== e.r2)
                        report_mismatch("row_two", row_two, e.r2);
                    if (row_three !== e.r3)
                        report_mismatch("row_three", row_three, e.r3);
                    if (last_column !== e.last)
                        report_mismatch("last_column", last_column, e.last);
                end
            end
        end
        columns_pending = expected_columns.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the model-matrix builder: clock, reset, stimulus and verdict.
// Depends on trs_model_matrix_build_top (and trsmb_pkg) and on trsmb_checker.
module tb_top;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [15:0]        angle_x, angle_y, angle_z;
    logic signed [31:0] scale_x, scale_y, scale_z;
    logic               strobe;
    logic [1:0]         column_index;
    logic signed [31:0] row_zero, row_one, row_two, row_three;
    logic               last_column;
    int                 fail_count;
    int                 columns_pending;
    int                 idle_cycles;

    // No stretch with nothing accepted should last anywhere near this long,
    // given the block's latency and the sender's longest pause.
    localparam int WatchdogLimit = 2000;

    trs_model_matrix_build_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
        .strobe(strobe), .column_index(column_index),
        .row_zero(row_zero), .row_one(row_one), .row_two(row_two),
        .row_three(row_three), .last_column(last_column)
    );

    trsmb_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
        .strobe(strobe), .column_index(column_index),
        .row_zero(row_zero), .row_one(row_one), .row_two(row_two),
        .row_three(row_three), .last_column(last_column),
        .fail_count(fail_count), .columns_pending(columns_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The watchdog counts cycles in which neither a start beat nor a column
    // beat is taken, and gives up once that stretch gets far too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Holds one item on the inputs with start raised until the block takes the beat.
    task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [15:0] ax,
                             input logic [15:0] ay, input logic [15:0] az,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz);
        start   <= 1'b1;
        pos_x   <= px; pos_y <= py; pos_z <= pz;
        angle_x <= ax; angle_y <= ay; angle_z <= az;
        scale_x <= sx; scale_y <= sy; scale_z <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Lowers start and lets the given number of cycles go by.
    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Random scale: mostly moderate values, sometimes raw 32-bit values that
    // drive the scaled entries into saturation.
    function automatic logic [31:0] rand_scale();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
    endfunction

    // Angles near the quadrant boundaries are where the split is most fragile.
    function automatic logic [15:0] rand_angle();
        if ($urandom_range(3) == 0)
            return 16'(($urandom_range(3) * 16384 + 8192 + $urandom_range(4) - 2));
        return 16'($urandom);
    endfunction

    initial
    begin
        int burst;
        logic [15:0] edge_angles[10];
        edge_angles = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd24575,
                        16'd32768, 16'd40960, 16'd49152, 16'd57343, 16'hFFFF};
        rst_n   = 1'b0;
        start   = 1'b0;
        pos_x   = '0; pos_y = '0; pos_z = '0;
        angle_x = '0; angle_y = '0; angle_z = '0;
        scale_x = '0; scale_y = '0; scale_z = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: identity, angle wrap at every quadrant edge,
        // extreme positions and scales that saturate in both directions.
        send_item(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000);
        foreach (edge_angles[i])
            send_item($urandom, $urandom, $urandom, edge_angles[i],
                      edge_angles[(i + 3) % 10], edge_angles[(i + 7) % 10],
                      32'h10000, 32'hFFFF0000, 32'h00020000);
        send_item(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0, 0, 0,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(32'h80000000, 32'h7FFFFFFF, 0, 16'd32768, 16'd16384, 16'd49152,
                  32'h80000000, 32'h80000000, 32'h80000000);
        send_item(32'hFFFFFFFF, 0, 32'h80000000, 16'd8192, 16'd8192, 16'd8192,
                  32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_item(1, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1, 32'h80000001);

        // Let the pipeline drain completely once before the random part.
        start <= 1'b0;
        while (columns_pending != 0)
            @(posedge clk);

        // Random part in bursts with random gaps, some bursts back to back.
        for (int n = 0; n < 100; n += burst)
        begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst; k++)
                send_item($urandom, $urandom, $urandom, rand_angle(), rand_angle(),
                          rand_angle(), rand_scale(), rand_scale(), rand_scale());
            if ($urandom_range(2) != 0)
                pause_sender($urandom_range(1, 12));
        end

        start <= 1'b0;
        while (columns_pending != 0)
            @(posedge clk);
        // A few extra cycles to catch any stray beat after the last column.
        repeat (30)
            @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== trs_model_matrix_build_top.f =====
src/trsmb_pkg.sv
src/trsmb_sincos.sv
src/trs_model_matrix_build_top.sv
bench/trsmb_checker.sv
bench/tb_top.sv
